// File: src/ir_range_kalman_averager_top_macros.svh
// Assertion macros for the IR range Kalman averager
`ifndef IR_RANGE_KALMAN_AVERAGER_TOP_MACROS_SVH
`define IR_RANGE_KALMAN_AVERAGER_TOP_MACROS_SVH

// same-cycle implication
`define IRKA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IRKA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/irka_pkg.sv
// Shared constants and types for the IR range Kalman averager
package irka_pkg;

   localparam int ADC_BITS    = 10;
   localparam int FRAC_BITS   = 16;
   localparam int TABLE_DEPTH = 1 << ADC_BITS;

   localparam int DIST_W      = 24;
   localparam int NOISE_W     = 24;
   localparam int VAR_W       = 24;
   localparam int MEAN_W      = 32;
   localparam int CNT_W       = 8;
   localparam int OUT_W       = DIST_W + 1;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int DIST_SHIFT  = MEAN_W - DIST_W;
   localparam int STEP_CNT_W  = $clog2(FRAC_BITS + 1);

   localparam logic [FRAC_BITS:0]    K_ONE      = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [MEAN_W:0]       ROUND_HALF = (MEAN_W + 1)'(1) << (DIST_SHIFT - 1);

   localparam logic [CNT_W-1:0]      RST_SAMPLES  = CNT_W'(60);
   localparam logic [NOISE_W-1:0]    RST_PROC_NS  = NOISE_W'(655);
   localparam logic [NOISE_W-1:0]    RST_MEAS_NS  = NOISE_W'(65536);
   localparam logic [DIST_W-1:0]     RST_OFFSET   = DIST_W'(0);
   localparam logic [DIST_W-1:0]     RST_FALLBACK = DIST_W'(512000);

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLES    = 3'd0,
      CSR_PROC_NOISE = 3'd1,
      CSR_MEAS_NOISE = 3'd2,
      CSR_OFFSET     = 3'd3,
      CSR_FALLBACK   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              invalid;
      logic [DIST_W-1:0] distance;
   } table_entry_type;

endpackage

// File: src/irka_table.sv
// ADC code to distance conversion table, registered read
module irka_table (
   input  logic                             clock,
   input  logic                             write_enable,
   input  logic                             read_enable,
   input  logic [irka_pkg::ADC_BITS-1:0]    address,
   input  irka_pkg::table_entry_type        write_entry,
   output irka_pkg::table_entry_type        read_entry
);

   irka_pkg::table_entry_type mem [irka_pkg::TABLE_DEPTH];
   irka_pkg::table_entry_type read_entry_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[address] <= write_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_entry_ff <= mem[address];
      end
   end

   assign read_entry = read_entry_ff;

endmodule

// File: src/irka_divider.sv
// Bit-serial restoring divider for the Kalman gain, one quotient bit per cycle
module irka_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [irka_pkg::VAR_W-1:0]        numerator,
   input  logic [irka_pkg::VAR_W:0]          denominator,
   output logic                              done,
   output logic [irka_pkg::FRAC_BITS-1:0]    quotient
);

   logic [irka_pkg::VAR_W+1:0]      rem_ff, rem_in;
   logic [irka_pkg::VAR_W:0]        den_ff, den_in;
   logic [irka_pkg::FRAC_BITS-1:0]  quot_ff, quot_in;
   logic [irka_pkg::STEP_CNT_W-1:0] count_ff, count_in;
   logic                            active_ff, active_in;
   logic                            done_ff, done_in;

   logic [irka_pkg::VAR_W+1:0]      shifted;
   logic [irka_pkg::VAR_W+1:0]      reduced;
   logic                            fits;

   always_comb begin
      shifted = {rem_ff[irka_pkg::VAR_W:0], 1'b0};
      fits    = shifted >= {1'b0, den_ff};
      reduced = shifted - {1'b0, den_ff};
   end

   always_comb begin
      rem_in    = rem_ff;
      den_in    = den_ff;
      quot_in   = quot_ff;
      count_in  = count_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in    = {2'b00, numerator};
         den_in    = denominator;
         quot_in   = '0;
         count_in  = irka_pkg::STEP_CNT_W'(irka_pkg::FRAC_BITS);
         active_in = 1'b1;
      end else if (active_ff) begin
         rem_in   = fits ? reduced : shifted;
         quot_in  = {quot_ff[irka_pkg::FRAC_BITS-2:0], fits};
         count_in = count_ff - irka_pkg::STEP_CNT_W'(1);
         if (count_ff == irka_pkg::STEP_CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: src/irka_serial_mult.sv
// Bit-serial shift-add multiplier, result scaled down by the fraction width
module irka_serial_mult (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [irka_pkg::FRAC_BITS-1:0]    multiplier,
   input  logic [irka_pkg::MEAN_W-1:0]       multiplicand,
   output logic                              done,
   output logic [irka_pkg::MEAN_W-1:0]       product
);

   logic [irka_pkg::MEAN_W-1:0]     acc_ff, acc_in;
   logic [irka_pkg::MEAN_W-1:0]     mcand_ff, mcand_in;
   logic [irka_pkg::FRAC_BITS-1:0]  mplr_ff, mplr_in;
   logic [irka_pkg::STEP_CNT_W-1:0] count_ff, count_in;
   logic                            active_ff, active_in;
   logic                            done_ff, done_in;

   logic [irka_pkg::MEAN_W:0]       sum;

   always_comb begin
      sum = {1'b0, acc_ff} + (mplr_ff[0] ? {1'b0, mcand_ff} : '0);
   end

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplr_in   = mplr_ff;
      count_in  = count_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = multiplicand;
         mplr_in   = multiplier;
         count_in  = irka_pkg::STEP_CNT_W'(irka_pkg::FRAC_BITS);
         active_in = 1'b1;
      end else if (active_ff) begin
         acc_in   = sum[irka_pkg::MEAN_W:1];
         mplr_in  = mplr_ff >> 1;
         count_in = count_ff - irka_pkg::STEP_CNT_W'(1);
         if (count_ff == irka_pkg::STEP_CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: src/ir_range_kalman_averager_top.sv
// Top level: IR range sensor table lookup and scalar Kalman averaging
// Table load: written while idle. Valid sample, from acceptance to the next acceptance:
// lookup, serial divider, serial multipliers, finish, idle. Invalid: lookup, finish, idle.
// Result registered on leaving finish after a closing sample, valid or invalid;
// a closing sample holds in finish, input stalled, while the previous result waits.
// Synchronous reset clears control and estimate and loads configuration defaults; table is not cleared.
`include "ir_range_kalman_averager_top_macros.svh"

module ir_range_kalman_averager_top (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [irka_pkg::ADC_BITS-1:0]        req_adc_value,
   input  logic [irka_pkg::DIST_W-1:0]          req_table_distance,
   input  logic                                 req_table_invalid,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [irka_pkg::OUT_W-1:0]    rsp_distance,
   output logic                                 rsp_used_fallback,

   input  logic                                 csr_write_enable,
   input  logic [irka_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [irka_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   irka_pkg::state_type               state_ff, state_in;

   logic [irka_pkg::CNT_W-1:0]        spm_ff;
   logic [irka_pkg::NOISE_W-1:0]      proc_noise_ff;
   logic [irka_pkg::NOISE_W-1:0]      meas_noise_ff;
   logic [irka_pkg::DIST_W-1:0]       offset_ff;
   logic [irka_pkg::DIST_W-1:0]       fallback_ff;

   logic [irka_pkg::MEAN_W-1:0]       mean_ff, mean_in;
   logic [irka_pkg::VAR_W-1:0]        var_ff, var_in;
   logic [irka_pkg::CNT_W-1:0]        count_ff, count_in;
   logic                              saw_ff, saw_in;

   logic [irka_pkg::VAR_W-1:0]        s_ff, s_in;
   logic [irka_pkg::DIST_W-1:0]       dist_ff, dist_in;
   logic [irka_pkg::MEAN_W-1:0]       diff_ff, diff_in;
   logic                              up_ff, up_in;
   logic                              k_one_ff, k_one_in;
   logic                              omk_one_ff, omk_one_in;

   logic                              rsp_valid_ff;
   logic signed [irka_pkg::OUT_W-1:0] rsp_distance_ff, rsp_distance_in;
   logic                              rsp_fallback_ff, rsp_fallback_in;

   logic                              req_accept;
   logic                              table_we;
   logic                              div_start;
   logic                              mult_start;
   logic                              rsp_load;

   irka_pkg::table_entry_type         wr_entry;
   irka_pkg::table_entry_type         rd_entry;

   logic                              div_done;
   logic [irka_pkg::FRAC_BITS-1:0]    div_quot;
   logic                              mean_done;
   logic                              var_done;
   logic [irka_pkg::MEAN_W-1:0]       mean_prod;
   logic [irka_pkg::MEAN_W-1:0]       var_prod;

   logic [irka_pkg::VAR_W:0]          s_sum;
   logic [irka_pkg::VAR_W-1:0]        s_sat;
   logic [irka_pkg::VAR_W:0]          den;
   logic [irka_pkg::FRAC_BITS:0]      k_full;
   logic [irka_pkg::FRAC_BITS:0]      omk;
   logic [irka_pkg::MEAN_W-1:0]       target;
   logic                              up;
   logic [irka_pkg::MEAN_W-1:0]       diff;
   logic [irka_pkg::MEAN_W-1:0]       step;
   logic [irka_pkg::MEAN_W-1:0]       mean_upd;
   logic [irka_pkg::VAR_W-1:0]        var_upd;
   logic [irka_pkg::CNT_W-1:0]        cnt_next;
   logic                              run_end;
   logic                              out_free;
   logic [irka_pkg::MEAN_W:0]         round_sum;
   logic [irka_pkg::OUT_W-1:0]        mean_result;

   assign req_accept = req_valid && req_ready;
   assign wr_entry   = '{invalid: req_table_invalid, distance: req_table_distance};

   irka_table u_table (
      .clock        (clock),
      .write_enable (table_we),
      .read_enable  (req_accept),
      .address      (req_adc_value),
      .write_entry  (wr_entry),
      .read_entry   (rd_entry)
   );

   irka_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (s_sat),
      .denominator (den),
      .done        (div_done),
      .quotient    (div_quot)
   );

   irka_serial_mult u_mean_mult (
      .clock        (clock),
      .reset        (reset),
      .start        (mult_start),
      .multiplier   (k_full[irka_pkg::FRAC_BITS-1:0]),
      .multiplicand (diff),
      .done         (mean_done),
      .product      (mean_prod)
   );

   irka_serial_mult u_var_mult (
      .clock        (clock),
      .reset        (reset),
      .start        (mult_start),
      .multiplier   (omk[irka_pkg::FRAC_BITS-1:0]),
      .multiplicand ({{(irka_pkg::MEAN_W - irka_pkg::VAR_W){1'b0}}, s_ff}),
      .done         (var_done),
      .product      (var_prod)
   );

   // datapath arithmetic
   always_comb begin
      s_sum  = {1'b0, var_ff} + {1'b0, proc_noise_ff};
      s_sat  = s_sum[irka_pkg::VAR_W] ? {irka_pkg::VAR_W{1'b1}} : s_sum[irka_pkg::VAR_W-1:0];
      den    = {1'b0, s_sat} + {1'b0, meas_noise_ff};
      // zero measurement noise: gain is one, or zero when S is zero too
      if (meas_noise_ff == '0) begin
         k_full = (s_ff != '0) ? irka_pkg::K_ONE : '0;
      end else begin
         k_full = {1'b0, div_quot};
      end
      omk    = irka_pkg::K_ONE - k_full;
      target = {dist_ff, {irka_pkg::DIST_SHIFT{1'b0}}};
      up     = target >= mean_ff;
      diff   = up ? (target - mean_ff) : (mean_ff - target);
      step   = k_one_ff ? diff_ff : mean_prod;
      mean_upd = up_ff ? (mean_ff + step) : (mean_ff - step);
      var_upd  = omk_one_ff ? s_ff : var_prod[irka_pkg::VAR_W-1:0];
      cnt_next = count_ff + irka_pkg::CNT_W'(1);
      run_end  = cnt_next >= spm_ff;
      out_free = !rsp_valid_ff || rsp_ready;
      round_sum   = {1'b0, mean_ff} + irka_pkg::ROUND_HALF;
      mean_result = round_sum[irka_pkg::MEAN_W:irka_pkg::DIST_SHIFT] - {1'b0, offset_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         irka_pkg::ST_IDLE: begin
            if (req_accept && req_command == irka_pkg::CMD_SAMPLE) begin
               state_in = irka_pkg::ST_LOOKUP;
            end
         end
         irka_pkg::ST_LOOKUP: begin
            state_in = rd_entry.invalid ? irka_pkg::ST_FINISH : irka_pkg::ST_DIVIDE;
         end
         irka_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = irka_pkg::ST_MULTIPLY;
            end
         end
         irka_pkg::ST_MULTIPLY: begin
            if (mean_done) begin
               state_in = irka_pkg::ST_FINISH;
            end
         end
         irka_pkg::ST_FINISH: begin
            if (!run_end || out_free) begin
               state_in = irka_pkg::ST_IDLE;
            end
         end
         default: state_in = irka_pkg::ST_IDLE;
      endcase
   end

   // outputs and register updates
   always_comb begin
      req_ready       = (state_ff == irka_pkg::ST_IDLE);
      table_we        = 1'b0;
      div_start       = 1'b0;
      mult_start      = 1'b0;
      rsp_load        = 1'b0;
      mean_in         = mean_ff;
      var_in          = var_ff;
      count_in        = count_ff;
      saw_in          = saw_ff;
      s_in            = s_ff;
      dist_in         = dist_ff;
      diff_in         = diff_ff;
      up_in           = up_ff;
      k_one_in        = k_one_ff;
      omk_one_in      = omk_one_ff;
      rsp_distance_in = rsp_distance_ff;
      rsp_fallback_in = rsp_fallback_ff;
      case (state_ff)
         irka_pkg::ST_IDLE: begin
            table_we = req_valid && (req_command == irka_pkg::CMD_LOAD);
         end
         irka_pkg::ST_LOOKUP: begin
            if (rd_entry.invalid) begin
               saw_in = 1'b1;
            end else begin
               div_start = 1'b1;
               s_in      = s_sat;
               dist_in   = rd_entry.distance;
            end
         end
         irka_pkg::ST_DIVIDE: begin
            if (div_done) begin
               mult_start = 1'b1;
               diff_in    = diff;
               up_in      = up;
               k_one_in   = k_full[irka_pkg::FRAC_BITS];
               omk_one_in = omk[irka_pkg::FRAC_BITS];
            end
         end
         irka_pkg::ST_MULTIPLY: begin
            if (mean_done) begin
               mean_in = mean_upd;
               var_in  = var_upd;
            end
         end
         irka_pkg::ST_FINISH: begin
            if (!run_end) begin
               count_in = cnt_next;
            end else if (out_free) begin
               rsp_load        = 1'b1;
               rsp_distance_in = saw_ff ? {1'b0, fallback_ff} : mean_result;
               rsp_fallback_in = saw_ff;
               mean_in         = '0;
               var_in          = '0;
               count_in        = '0;
               saw_in          = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= irka_pkg::ST_IDLE;
         mean_ff      <= '0;
         var_ff       <= '0;
         count_ff     <= '0;
         saw_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mean_ff  <= mean_in;
         var_ff   <= var_in;
         count_ff <= count_in;
         saw_ff   <= saw_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff            <= s_in;
      dist_ff         <= dist_in;
      diff_ff         <= diff_in;
      up_ff           <= up_in;
      k_one_ff        <= k_one_in;
      omk_one_ff      <= omk_one_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_fallback_ff <= rsp_fallback_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         spm_ff        <= irka_pkg::RST_SAMPLES;
         proc_noise_ff <= irka_pkg::RST_PROC_NS;
         meas_noise_ff <= irka_pkg::RST_MEAS_NS;
         offset_ff     <= irka_pkg::RST_OFFSET;
         fallback_ff   <= irka_pkg::RST_FALLBACK;
      end else if (csr_write_enable) begin
         case (csr_index)
            irka_pkg::CSR_SAMPLES:    spm_ff        <= csr_write_data[irka_pkg::CNT_W-1:0];
            irka_pkg::CSR_PROC_NOISE: proc_noise_ff <= csr_write_data[irka_pkg::NOISE_W-1:0];
            irka_pkg::CSR_MEAS_NOISE: meas_noise_ff <= csr_write_data[irka_pkg::NOISE_W-1:0];
            irka_pkg::CSR_OFFSET:     offset_ff     <= csr_write_data[irka_pkg::DIST_W-1:0];
            irka_pkg::CSR_FALLBACK:   fallback_ff   <= csr_write_data[irka_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_distance      = rsp_distance_ff;
   assign rsp_used_fallback = rsp_fallback_ff;

   `IRKA_ASSERT_SAME(a_div_done_in_divide, clock, reset, div_done, state_ff == irka_pkg::ST_DIVIDE, "divider finished outside divide state")
   `IRKA_ASSERT_SAME(a_mult_lockstep, clock, reset, mean_done || var_done, mean_done && var_done, "serial multipliers out of step")
   `IRKA_ASSERT_SAME(a_var_bounded, clock, reset, mean_done, var_upd <= s_ff, "variance update exceeds predicted variance")
   `IRKA_ASSERT_NEXT(a_restart_after_result, clock, reset, rsp_load, count_ff == '0 && !saw_ff && mean_ff == '0 && rsp_valid_ff, "estimate not restarted after result")

endmodule
